@@ rtl/gpdk_pkg.sv @@
// gpdk_pkg: shared types, register indexes, key codes and reset values for
// the gamepad poll to down-key block. Used by every rtl/ file but the interfaces.
package gpdk_pkg;

    localparam int unsigned KEY_W      = 16;
    localparam int unsigned NUM_BTN    = 16;
    localparam int unsigned NUM_SRC    = NUM_BTN + 4;  // buttons, two triggers, two sticks
    localparam int unsigned SRC_IDX_W  = $clog2(NUM_SRC);
    localparam int unsigned MAX_KEYS   = 18;
    localparam int unsigned CNT_W      = $clog2(MAX_KEYS);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LT_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RT_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LS_DZ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RS_DZ    = 3'd4;

    localparam logic [15:0] RST_BTN_MASK = 16'd62463;
    localparam logic [7:0]  RST_LT_THR   = 8'd30;
    localparam logic [7:0]  RST_RT_THR   = 8'd30;
    localparam logic [15:0] RST_LS_DZ    = 16'd7849;
    localparam logic [15:0] RST_RS_DZ    = 16'd8689;

    // tan(pi/8) in Q16
    localparam logic [14:0] TAN_PI8_Q16 = 15'd27146;

    localparam logic [KEY_W-1:0] KEY_NONE = 16'd0;
    localparam logic [KEY_W-1:0] KEY_LT   = 16'd201;
    localparam logic [KEY_W-1:0] KEY_RT   = 16'd202;

    typedef enum logic [2:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_RIGHT,
        DIR_LEFT,
        DIR_UP_LEFT,
        DIR_UP_RIGHT,
        DIR_DOWN_RIGHT,
        DIR_DOWN_LEFT
    } t_dir;

    localparam logic [KEY_W-1:0] LEFT_CODES [8] = '{
        16'd211, 16'd212, 16'd213, 16'd214,
        16'd22564, 16'd22565, 16'd22566, 16'd22567
    };
    localparam logic [KEY_W-1:0] RIGHT_CODES [8] = '{
        16'd215, 16'd216, 16'd217, 16'd218,
        16'd22580, 16'd22581, 16'd22582, 16'd22583
    };

    typedef struct packed {
        logic [15:0] btn_mask;
        logic [7:0]  lt_thr;
        logic [7:0]  rt_thr;
        logic [15:0] ls_dz;
        logic [15:0] rs_dz;
    } t_cfg;

    // evaluated poll handed from the evaluator to the emitter
    typedef struct packed {
        logic [NUM_BTN-1:0] buttons;
        logic               lt_hit;
        logic               rt_hit;
        logic               ls_act;
        logic               rs_act;
        t_dir               ls_dir;
        t_dir               rs_dir;
    } t_eval;

    function automatic logic [KEY_W-1:0] stick_key(input logic right, input t_dir d);
        return right ? RIGHT_CODES[d] : LEFT_CODES[d];
    endfunction

endpackage

@@ rtl/gpdk_poll_if.sv @@
// gpdk_poll_if: poll channel, one gamepad poll per word.
// Depends on nothing.
interface gpdk_poll_if;
    logic               valid;
    logic               ready;
    logic        [15:0] button_bits;
    logic        [7:0]  left_trigger;
    logic        [7:0]  right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;

    modport source (
        output valid, button_bits, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink (
        input  valid, button_bits, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

@@ rtl/gpdk_key_if.sv @@
// gpdk_key_if: key channel, one down-key result per word.
// Depends on nothing.
interface gpdk_key_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_code;
    logic        none_down;
    logic        last_of_poll;

    modport source (output valid, key_code, none_down, last_of_poll, input ready);
    modport sink   (input  valid, key_code, none_down, last_of_poll, output ready);
endinterface

@@ rtl/gpdk_cfg_if.sv @@
// gpdk_cfg_if: register write channel, index and data per word.
// Depends on nothing.
interface gpdk_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

@@ rtl/gpdk_cfg_regs.sv @@
// gpdk_cfg_regs: configuration register file written over the cfg channel.
// Depends on gpdk_pkg and gpdk_cfg_if.
module gpdk_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gpdk_cfg_if.sink        i_cfg,
    output gpdk_pkg::t_cfg  o_cfg
);

    gpdk_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btn_mask <= gpdk_pkg::RST_BTN_MASK;
            r_cfg.lt_thr   <= gpdk_pkg::RST_LT_THR;
            r_cfg.rt_thr   <= gpdk_pkg::RST_RT_THR;
            r_cfg.ls_dz    <= gpdk_pkg::RST_LS_DZ;
            r_cfg.rs_dz    <= gpdk_pkg::RST_RS_DZ;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gpdk_pkg::CFG_BTN_MASK: r_cfg.btn_mask <= i_cfg.data;
                gpdk_pkg::CFG_LT_THR:   r_cfg.lt_thr   <= i_cfg.data[7:0];
                gpdk_pkg::CFG_RT_THR:   r_cfg.rt_thr   <= i_cfg.data[7:0];
                gpdk_pkg::CFG_LS_DZ:    r_cfg.ls_dz    <= i_cfg.data;
                gpdk_pkg::CFG_RS_DZ:    r_cfg.rs_dz    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/gpdk_stick.sv @@
// gpdk_stick: two-stage stick classifier, squares and tangent products first,
// then deadzone test and sector choice. Depends on gpdk_pkg.
module gpdk_stick (
    input  logic               i_clk,
    input  logic               i_ld_b,
    input  logic               i_ld_c,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic        [15:0] i_dz,
    output logic               o_act,
    output gpdk_pkg::t_dir     o_dir
);

    logic [15:0] xu, yu, ax, ay;
    logic [30:0] r_ax2, r_ay2;
    logic [31:0] r_d2;
    logic [29:0] r_axk, r_ayk;
    logic [15:0] r_ax, r_ay;
    logic        r_xneg, r_xpos, r_yneg, r_ypos, r_zero;

    logic [31:0] r2;
    logic        horiz, vert, act;
    gpdk_pkg::t_dir dir;
    logic        r_act;
    gpdk_pkg::t_dir r_dir;

    assign xu = i_x;
    assign yu = i_y;
    // magnitude fits 16 bits unsigned, including the most negative value
    assign ax = xu[15] ? (~xu + 16'd1) : xu;
    assign ay = yu[15] ? (~yu + 16'd1) : yu;

    always_ff @(posedge i_clk) begin
        if (i_ld_b) begin
            r_ax2  <= 31'(ax) * 31'(ax);
            r_ay2  <= 31'(ay) * 31'(ay);
            r_d2   <= 32'(i_dz) * 32'(i_dz);
            r_axk  <= 30'(ax) * 30'(gpdk_pkg::TAN_PI8_Q16);
            r_ayk  <= 30'(ay) * 30'(gpdk_pkg::TAN_PI8_Q16);
            r_ax   <= ax;
            r_ay   <= ay;
            r_xneg <= xu[15];
            r_xpos <= !xu[15] && (xu != 16'd0);
            r_yneg <= yu[15];
            r_ypos <= !yu[15] && (yu != 16'd0);
            r_zero <= (xu == 16'd0) && (yu == 16'd0);
        end
    end

    always_comb begin
        r2    = 32'(r_ax2) + 32'(r_ay2);
        act   = !r_zero && (r2 > r_d2);
        // ties on a sector edge go to the axis, horizontal first
        horiz = {r_ay, 16'd0} <= {2'd0, r_axk};
        vert  = {r_ax, 16'd0} <= {2'd0, r_ayk};
        if (horiz) begin
            dir = r_xneg ? gpdk_pkg::DIR_LEFT : gpdk_pkg::DIR_RIGHT;
        end else if (vert) begin
            dir = r_yneg ? gpdk_pkg::DIR_DOWN : gpdk_pkg::DIR_UP;
        end else if (r_ypos) begin
            dir = r_xpos ? gpdk_pkg::DIR_UP_RIGHT : gpdk_pkg::DIR_UP_LEFT;
        end else begin
            dir = r_xpos ? gpdk_pkg::DIR_DOWN_RIGHT : gpdk_pkg::DIR_DOWN_LEFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_c) begin
            r_act <= act;
            r_dir <= dir;
        end
    end

    assign o_act = r_act;
    assign o_dir = r_dir;

endmodule

@@ rtl/gpdk_eval.sv @@
// gpdk_eval: three-stage evaluator: poll register, products, active flags.
// Depends on gpdk_pkg, gpdk_poll_if and gpdk_stick.
module gpdk_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpdk_pkg::t_cfg    i_cfg,
    gpdk_poll_if.sink         i_poll,
    output logic              o_valid,
    input  logic              i_ready,
    output gpdk_pkg::t_eval   o_eval
);

    logic r_a_v, r_b_v, r_c_v;
    logic rdy_a, rdy_b, rdy_c;
    logic ld_a, ld_b, ld_c;

    logic        [15:0] r_a_btn;
    logic        [7:0]  r_a_lt, r_a_rt;
    logic signed [15:0] r_a_lx, r_a_ly, r_a_rx, r_a_ry;

    logic [15:0] r_b_btn, r_c_btn;
    logic        r_b_lt, r_b_rt, r_c_lt, r_c_rt;

    logic           ls_act, rs_act;
    gpdk_pkg::t_dir ls_dir, rs_dir;

    assign rdy_c = !r_c_v || i_ready;
    assign rdy_b = !r_b_v || rdy_c;
    assign rdy_a = !r_a_v || rdy_b;
    assign ld_a  = i_poll.valid && rdy_a;
    assign ld_b  = r_a_v && rdy_b;
    assign ld_c  = r_b_v && rdy_c;

    assign i_poll.ready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_poll.valid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_btn <= i_poll.button_bits;
            r_a_lt  <= i_poll.left_trigger;
            r_a_rt  <= i_poll.right_trigger;
            r_a_lx  <= i_poll.left_x;
            r_a_ly  <= i_poll.left_y;
            r_a_rx  <= i_poll.right_x;
            r_a_ry  <= i_poll.right_y;
        end
        if (ld_b) begin
            r_b_btn <= r_a_btn & i_cfg.btn_mask;
            r_b_lt  <= r_a_lt > i_cfg.lt_thr;
            r_b_rt  <= r_a_rt > i_cfg.rt_thr;
        end
        if (ld_c) begin
            r_c_btn <= r_b_btn;
            r_c_lt  <= r_b_lt;
            r_c_rt  <= r_b_rt;
        end
    end

    gpdk_stick u_left (
        .i_clk  (i_clk),
        .i_ld_b (ld_b),
        .i_ld_c (ld_c),
        .i_x    (r_a_lx),
        .i_y    (r_a_ly),
        .i_dz   (i_cfg.ls_dz),
        .o_act  (ls_act),
        .o_dir  (ls_dir)
    );

    gpdk_stick u_right (
        .i_clk  (i_clk),
        .i_ld_b (ld_b),
        .i_ld_c (ld_c),
        .i_x    (r_a_rx),
        .i_y    (r_a_ry),
        .i_dz   (i_cfg.rs_dz),
        .o_act  (rs_act),
        .o_dir  (rs_dir)
    );

    assign o_valid        = r_c_v;
    assign o_eval.buttons = r_c_btn;
    assign o_eval.lt_hit  = r_c_lt;
    assign o_eval.rt_hit  = r_c_rt;
    assign o_eval.ls_act  = ls_act;
    assign o_eval.rs_act  = rs_act;
    assign o_eval.ls_dir  = ls_dir;
    assign o_eval.rs_dir  = rs_dir;

endmodule

@@ rtl/gpdk_emit.sv @@
// gpdk_emit: walks one poll's active set, lowest source first, into an output
// register, one key word per cycle unless o_key stalls. Uses gpdk_pkg, gpdk_key_if.
module gpdk_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gpdk_pkg::t_eval   i_eval,
    gpdk_key_if.source        o_key
);

    localparam int unsigned NS = gpdk_pkg::NUM_SRC;
    localparam int unsigned NB = gpdk_pkg::NUM_BTN;
    localparam int unsigned KW = gpdk_pkg::KEY_W;
    localparam int unsigned CW = gpdk_pkg::CNT_W;

    logic [NS-1:0]   r_pend, n_pend;
    logic            r_busy, n_busy;
    logic            r_none, n_none;
    logic [CW-1:0]   r_cnt, n_cnt;
    gpdk_pkg::t_dir  r_ls_dir, r_rs_dir;

    logic            r_o_v, n_o_v;
    logic [KW-1:0]   r_o_code, n_o_code;
    logic            r_o_none, n_o_none;
    logic            r_o_last, n_o_last;

    logic [NS-1:0]   src_in, pick, rest;
    logic [KW-1:0]   code;
    logic            out_free, emit, last, load;

    assign src_in = {i_eval.rs_act, i_eval.ls_act, i_eval.rt_hit, i_eval.lt_hit,
                     i_eval.buttons};

    always_comb begin
        // isolate the lowest pending source
        pick = r_pend & (~r_pend + NS'(1));
        rest = r_pend & ~pick;
        code = gpdk_pkg::KEY_NONE;
        for (int i = 0; i < NB; i++) begin
            if (pick[i]) code = code | (KW'(1) << i);
        end
        if (pick[NB])     code = code | gpdk_pkg::KEY_LT;
        if (pick[NB + 1]) code = code | gpdk_pkg::KEY_RT;
        if (pick[NB + 2]) code = code | gpdk_pkg::stick_key(1'b0, r_ls_dir);
        if (pick[NB + 3]) code = code | gpdk_pkg::stick_key(1'b1, r_rs_dir);

        out_free = !r_o_v || o_key.ready;
        emit     = r_busy && out_free;
        last     = r_none || (rest == '0) || (r_cnt == CW'(gpdk_pkg::MAX_KEYS - 1));
        o_ready  = !r_busy || (out_free && last);
        load     = i_valid && o_ready;

        n_pend   = r_pend;
        n_busy   = r_busy;
        n_none   = r_none;
        n_cnt    = r_cnt;
        n_o_v    = r_o_v && !o_key.ready;
        n_o_code = r_o_code;
        n_o_none = r_o_none;
        n_o_last = r_o_last;

        if (emit) begin
            n_o_v    = 1'b1;
            n_o_code = r_none ? gpdk_pkg::KEY_NONE : code;
            n_o_none = r_none;
            n_o_last = last;
            n_pend   = rest;
            n_cnt    = r_cnt + CW'(1);
            if (last) n_busy = 1'b0;
        end
        if (load) begin
            n_pend = src_in;
            n_busy = 1'b1;
            n_none = (src_in == '0);
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_o_v  <= n_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_none   <= n_none;
        r_cnt    <= n_cnt;
        r_o_code <= n_o_code;
        r_o_none <= n_o_none;
        r_o_last <= n_o_last;
        if (load) begin
            r_ls_dir <= i_eval.ls_dir;
            r_rs_dir <= i_eval.rs_dir;
        end
    end

    assign o_key.valid        = r_o_v;
    assign o_key.key_code     = r_o_code;
    assign o_key.none_down    = r_o_none;
    assign o_key.last_of_poll = r_o_last;

endmodule

@@ rtl/gamepad_state_to_down_keys.sv @@
// gamepad_state_to_down_keys: gamepad poll to down-key list, top level.
// Depends on gpdk_pkg, the gpdk_*_if interfaces, gpdk_cfg_regs, gpdk_eval, gpdk_emit.
//
//   channel  dir  word                                          handshake
//   i_poll   in   buttons, two triggers, two stick x/y pairs    valid/ready
//   o_key    out  key_code, none_down, last_of_poll             valid/ready
//   i_cfg    in   register index, write data                    valid/ready (ready high)
//
// A poll gives max(1, min(n, 18)) key words, n = active inputs, one per cycle
// unless o_key stalls. The output walker sets the rate, and the next poll is
// taken in the cycle its predecessor's last word goes out. After the poll is
// accepted, the first word passes two more evaluation stages, the walker and
// the output register. Stalls on o_key back up through the stages.
// Reset is synchronous; it clears the valid flags and restores register defaults.
module gamepad_state_to_down_keys (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpdk_poll_if.sink   i_poll,
    gpdk_key_if.source  o_key,
    gpdk_cfg_if.sink    i_cfg
);

    gpdk_pkg::t_cfg  cfg;
    gpdk_pkg::t_eval ev;
    logic            ev_valid, ev_ready;

    gpdk_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gpdk_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_poll  (i_poll),
        .o_valid (ev_valid),
        .i_ready (ev_ready),
        .o_eval  (ev)
    );

    gpdk_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ev_valid),
        .o_ready (ev_ready),
        .i_eval  (ev),
        .o_key   (o_key)
    );

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for gamepad_state_to_down_keys.
// Drives polls and register writes, predicts or looks up every down-key word and checks it.
// Depends on gpdk_pkg and the gpdk_poll_if, gpdk_key_if, gpdk_cfg_if interfaces.
module testbench;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int NUM_ROWS        = 25;

    // no register lives here, writes to it must change nothing
    localparam logic [gpdk_pkg::CFG_IDX_W-1:0] CFG_BAD_IDX = 3'd6;

    localparam logic [15:0] Z16        = 16'h0000;
    localparam logic [15:0] AXIS_HI    = 16'h7FFF;
    localparam logic [15:0] AXIS_LO    = 16'h8000;
    // 13573 * 65536 == 32768 * 27146: puts a full-scale stick exactly on a 22.5 degree edge
    localparam logic [15:0] EDGE_MINOR = 16'd13573;

    typedef struct packed {
        logic        [15:0] button_bits;
        logic        [7:0]  left_trigger;
        logic        [7:0]  right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } t_poll;

    typedef struct packed {
        logic [gpdk_pkg::KEY_W-1:0] key_code;
        logic                       none_down;
        logic                       last_of_poll;
    } t_key_word;

    // known set: the poll gives the single word key_code/none_down
    typedef struct packed {
        t_poll                      poll;
        logic                       known;
        logic [gpdk_pkg::KEY_W-1:0] key_code;
        logic                       none_down;
    } t_row;

    // reset register values throughout
    localparam t_row POLL_TAB [NUM_ROWS] = '{
        '{'{16'h0000, 8'd0, 8'd0, Z16, Z16, Z16, Z16}, 1'b1, gpdk_pkg::KEY_NONE, 1'b1},
        '{'{16'h0001, 8'd0, 8'd0, Z16, Z16, Z16, Z16}, 1'b1, 16'd1, 1'b0},
        '{'{16'h0C00, 8'd0, 8'd0, Z16, Z16, Z16, Z16}, 1'b1, gpdk_pkg::KEY_NONE, 1'b1},
        '{'{16'hFFFF, 8'd0, 8'd0, Z16, Z16, Z16, Z16}, 1'b0, gpdk_pkg::KEY_NONE, 1'b0},
        '{'{16'h0000, 8'd255, 8'd0, Z16, Z16, Z16, Z16}, 1'b1, gpdk_pkg::KEY_LT, 1'b0},
        '{'{16'h0000, 8'd0, 8'd255, Z16, Z16, Z16, Z16}, 1'b1, gpdk_pkg::KEY_RT, 1'b0},
        '{'{16'h0000, 8'd30, 8'd30, Z16, Z16, Z16, Z16}, 1'b1, gpdk_pkg::KEY_NONE, 1'b1},
        '{'{16'h0000, 8'd31, 8'd31, Z16, Z16, Z16, Z16}, 1'b0, gpdk_pkg::KEY_NONE, 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_HI, Z16, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_RIGHT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_LO, Z16, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_LEFT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, Z16, AXIS_HI, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_UP], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, Z16, AXIS_LO, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_DOWN], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_HI, AXIS_HI, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_UP_RIGHT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_LO, AXIS_HI, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_UP_LEFT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_HI, AXIS_LO, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_DOWN_RIGHT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_LO, AXIS_LO, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_DOWN_LEFT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, Z16, Z16, AXIS_HI, AXIS_HI}, 1'b1,
          gpdk_pkg::RIGHT_CODES[gpdk_pkg::DIR_UP_RIGHT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, Z16, Z16, Z16, AXIS_LO}, 1'b1,
          gpdk_pkg::RIGHT_CODES[gpdk_pkg::DIR_DOWN], 1'b0},
        // radius exactly on the deadzone, then just past it
        '{'{16'h0000, 8'd0, 8'd0, 16'd7849, Z16, Z16, Z16}, 1'b1,
          gpdk_pkg::KEY_NONE, 1'b1},
        '{'{16'h0000, 8'd0, 8'd0, 16'd7850, Z16, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_RIGHT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, Z16, Z16, -16'd8690, Z16}, 1'b1,
          gpdk_pkg::RIGHT_CODES[gpdk_pkg::DIR_LEFT], 1'b0},
        // on the horizontal edge, one step off it, on the vertical edge
        '{'{16'h0000, 8'd0, 8'd0, AXIS_LO, EDGE_MINOR, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_LEFT], 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, AXIS_LO, 16'd13574, Z16, Z16}, 1'b0,
          gpdk_pkg::KEY_NONE, 1'b0},
        '{'{16'h0000, 8'd0, 8'd0, EDGE_MINOR, AXIS_LO, Z16, Z16}, 1'b1,
          gpdk_pkg::LEFT_CODES[gpdk_pkg::DIR_DOWN], 1'b0},
        '{'{16'hFFFF, 8'd255, 8'd255, AXIS_HI, AXIS_HI, AXIS_LO, AXIS_LO}, 1'b0,
          gpdk_pkg::KEY_NONE, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gpdk_poll_if poll_ch ();
    gpdk_key_if  key_ch ();
    gpdk_cfg_if  cfg_ch ();

    gamepad_state_to_down_keys u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (poll_ch),
        .o_key   (key_ch),
        .i_cfg   (cfg_ch)
    );

    gpdk_pkg::t_cfg shadow_cfg = '{gpdk_pkg::RST_BTN_MASK, gpdk_pkg::RST_LT_THR,
                                   gpdk_pkg::RST_RT_THR, gpdk_pkg::RST_LS_DZ,
                                   gpdk_pkg::RST_RS_DZ};
    t_key_word key_expect_q [$];
    t_key_word known_word     = '0;
    logic      known_on       = 1'b0;
    logic      calm           = 1'b0;
    int        fault_cnt      = 0;
    int        idle_cycles    = 0;
    int        key_words      = 0;
    int        key_words_seen = 0;
    int        key_hold       = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic logic [gpdk_pkg::KEY_W-1:0] stick_direction_key(
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic [15:0]        dz,
        input logic               is_right
    );
        longint         ax;
        longint         ay;
        longint         r2;
        longint         d2;
        gpdk_pkg::t_dir d;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        r2 = ax * ax + ay * ay;
        d2 = longint'(dz) * longint'(dz);
        if (r2 == 0 || r2 <= d2) begin
            return gpdk_pkg::KEY_NONE;
        end
        // edges go to the axis, horizontal first
        if (ay * 65536 <= ax * longint'(gpdk_pkg::TAN_PI8_Q16)) begin
            d = (x >= 0) ? gpdk_pkg::DIR_RIGHT : gpdk_pkg::DIR_LEFT;
        end else if (ax * 65536 <= ay * longint'(gpdk_pkg::TAN_PI8_Q16)) begin
            d = (y >= 0) ? gpdk_pkg::DIR_UP : gpdk_pkg::DIR_DOWN;
        end else if (y > 0) begin
            d = (x > 0) ? gpdk_pkg::DIR_UP_RIGHT : gpdk_pkg::DIR_UP_LEFT;
        end else begin
            d = (x > 0) ? gpdk_pkg::DIR_DOWN_RIGHT : gpdk_pkg::DIR_DOWN_LEFT;
        end
        return is_right ? gpdk_pkg::RIGHT_CODES[d] : gpdk_pkg::LEFT_CODES[d];
    endfunction

    function automatic void predict_down_keys(input t_poll p);
        logic [gpdk_pkg::KEY_W-1:0]   keys [$];
        logic [gpdk_pkg::NUM_BTN-1:0] btn;
        logic [gpdk_pkg::KEY_W-1:0]   code;
        int                           n;
        btn = p.button_bits & shadow_cfg.btn_mask;
        for (int i = 0; i < gpdk_pkg::NUM_BTN; i++) begin
            if (btn[i]) begin
                keys.push_back(gpdk_pkg::KEY_W'(1) << i);
            end
        end
        if (p.left_trigger > shadow_cfg.lt_thr) begin
            keys.push_back(gpdk_pkg::KEY_LT);
        end
        if (p.right_trigger > shadow_cfg.rt_thr) begin
            keys.push_back(gpdk_pkg::KEY_RT);
        end
        code = stick_direction_key(p.left_x, p.left_y, shadow_cfg.ls_dz, 1'b0);
        if (code != gpdk_pkg::KEY_NONE) begin
            keys.push_back(code);
        end
        code = stick_direction_key(p.right_x, p.right_y, shadow_cfg.rs_dz, 1'b1);
        if (code != gpdk_pkg::KEY_NONE) begin
            keys.push_back(code);
        end
        if (keys.size() == 0) begin
            key_expect_q.push_back(t_key_word'{gpdk_pkg::KEY_NONE, 1'b1, 1'b1});
        end else begin
            // anything past the eighteenth key is dropped
            n = (keys.size() > gpdk_pkg::MAX_KEYS) ? int'(gpdk_pkg::MAX_KEYS) : keys.size();
            for (int i = 0; i < n; i++) begin
                key_expect_q.push_back(t_key_word'{keys[i], 1'b0, i == n - 1});
            end
        end
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0:       return Z16;
            1:       return AXIS_LO;
            2:       return AXIS_HI;
            3:       return 16'($urandom_range(0, 2000)) - 16'd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_trigger(input logic [7:0] thr);
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return thr;
            3:       return thr + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_poll rand_poll();
        t_poll p;
        case ($urandom_range(0, 5))
            0:       p.button_bits = 16'hFFFF;
            1:       p.button_bits = 16'h0000;
            default: p.button_bits = 16'($urandom);
        endcase
        p.left_trigger  = rand_trigger(shadow_cfg.lt_thr);
        p.right_trigger = rand_trigger(shadow_cfg.rt_thr);
        p.left_x        = rand_axis();
        p.left_y        = rand_axis();
        p.right_x       = rand_axis();
        p.right_y       = rand_axis();
        case ($urandom_range(0, 9))
            0: begin
                p.left_x = AXIS_LO;
                p.left_y = $urandom_range(0, 1) ? EDGE_MINOR : -EDGE_MINOR;
            end
            1: begin
                p.right_y = AXIS_LO;
                p.right_x = $urandom_range(0, 1) ? EDGE_MINOR : -EDGE_MINOR;
            end
            2: begin
                p.left_x = Z16;
                p.left_y = Z16;
            end
            3: begin
                p.right_x = Z16;
                p.right_y = Z16;
            end
            default: ;
        endcase
        return p;
    endfunction

    // entered and left at a falling edge
    task automatic send_poll(input t_poll p, input logic known, input t_key_word word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        poll_ch.button_bits   <= p.button_bits;
        poll_ch.left_trigger  <= p.left_trigger;
        poll_ch.right_trigger <= p.right_trigger;
        poll_ch.left_x        <= p.left_x;
        poll_ch.left_y        <= p.left_y;
        poll_ch.right_x       <= p.right_x;
        poll_ch.right_y       <= p.right_y;
        known_on   = known;
        known_word = word;
        poll_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!poll_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gpdk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        poll_ch.valid <= 1'b0;
        while (key_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            calm = (i >= 4 && i < 10);
            send_poll(rand_poll(), 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    // key side back-pressure: after each taken word hold ready low for the drawn cycles
    always @(negedge i_clk) begin
        if (key_words != key_words_seen) begin
            key_words_seen = key_words;
            key_hold       = calm ? 0 : $urandom_range(0, 9);
        end
        if (key_hold > 0) begin
            key_ch.ready <= 1'b0;
            key_hold--;
        end else begin
            key_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_poll     p;
        t_key_word got;
        t_key_word want;
        logic      took;
        took = 1'b0;
        if (!i_rst_n) begin
            shadow_cfg  = '{gpdk_pkg::RST_BTN_MASK, gpdk_pkg::RST_LT_THR,
                            gpdk_pkg::RST_RT_THR, gpdk_pkg::RST_LS_DZ,
                            gpdk_pkg::RST_RS_DZ};
            idle_cycles = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                took = 1'b1;
                case (cfg_ch.index)
                    gpdk_pkg::CFG_BTN_MASK: shadow_cfg.btn_mask = cfg_ch.data;
                    gpdk_pkg::CFG_LT_THR:   shadow_cfg.lt_thr   = cfg_ch.data[7:0];
                    gpdk_pkg::CFG_RT_THR:   shadow_cfg.rt_thr   = cfg_ch.data[7:0];
                    gpdk_pkg::CFG_LS_DZ:    shadow_cfg.ls_dz    = cfg_ch.data;
                    gpdk_pkg::CFG_RS_DZ:    shadow_cfg.rs_dz    = cfg_ch.data;
                    default: ;
                endcase
            end
            if (poll_ch.valid && poll_ch.ready) begin
                took = 1'b1;
                p = '{poll_ch.button_bits, poll_ch.left_trigger, poll_ch.right_trigger,
                      poll_ch.left_x, poll_ch.left_y, poll_ch.right_x, poll_ch.right_y};
                if (known_on) begin
                    key_expect_q.push_back(known_word);
                end else begin
                    predict_down_keys(p);
                end
            end
            if (key_ch.valid && key_ch.ready) begin
                took = 1'b1;
                got  = '{key_ch.key_code, key_ch.none_down, key_ch.last_of_poll};
                key_words++;
                if (key_expect_q.size() == 0) begin
                    note_fault($sformatf("unexpected word key %0d none %0b last %0b",
                                         got.key_code, got.none_down, got.last_of_poll));
                end else begin
                    want = key_expect_q.pop_front();
                    if (got.key_code !== want.key_code || got.none_down !== want.none_down ||
                        got.last_of_poll !== want.last_of_poll) begin
                        note_fault($sformatf(
                            "key %0d/%0d none %0b/%0b last %0b/%0b (expected/actual)",
                            want.key_code, got.key_code, want.none_down, got.none_down,
                            want.last_of_poll, got.last_of_poll));
                    end
                end
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        poll_ch.valid         = 1'b0;
        poll_ch.button_bits   = '0;
        poll_ch.left_trigger  = '0;
        poll_ch.right_trigger = '0;
        poll_ch.left_x        = '0;
        poll_ch.left_y        = '0;
        poll_ch.right_x       = '0;
        poll_ch.right_y       = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = gpdk_pkg::CFG_BTN_MASK;
        cfg_ch.data           = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (POLL_TAB[r]) begin
            calm = (r < 8);
            send_poll(POLL_TAB[r].poll, POLL_TAB[r].known,
                      t_key_word'{POLL_TAB[r].key_code, POLL_TAB[r].none_down, 1'b1});
        end
        calm = 1'b0;
        run_random(ITEMS_PER_PHASE);
        settle();

        // right trigger off, rest on, no deadzones: centred sticks, overflow past 18 keys
        write_reg(gpdk_pkg::CFG_BTN_MASK, 16'hFFFF);
        write_reg(gpdk_pkg::CFG_LT_THR, 16'd0);
        write_reg(gpdk_pkg::CFG_RT_THR, 16'd255);
        write_reg(gpdk_pkg::CFG_LS_DZ, 16'd0);
        write_reg(gpdk_pkg::CFG_RS_DZ, 16'd0);
        write_reg(CFG_BAD_IDX, 16'h1234);
        run_random(ITEMS_PER_PHASE);
        settle();

        // sticks can never be active
        write_reg(gpdk_pkg::CFG_BTN_MASK, 16'h0000);
        write_reg(gpdk_pkg::CFG_LT_THR, 16'd255);
        write_reg(gpdk_pkg::CFG_RT_THR, 16'd0);
        write_reg(gpdk_pkg::CFG_LS_DZ, 16'd46341);
        write_reg(gpdk_pkg::CFG_RS_DZ, 16'hFFFF);
        run_random(ITEMS_PER_PHASE);
        settle();

        write_reg(gpdk_pkg::CFG_BTN_MASK, 16'($urandom));
        write_reg(gpdk_pkg::CFG_LT_THR, 16'($urandom_range(0, 255)));
        write_reg(gpdk_pkg::CFG_RT_THR, 16'($urandom_range(0, 255)));
        write_reg(gpdk_pkg::CFG_LS_DZ, 16'($urandom_range(0, 46341)));
        write_reg(gpdk_pkg::CFG_RS_DZ, 16'($urandom_range(0, 46341)));
        run_random(ITEMS_PER_PHASE);
        settle();

        // only corners with a full negative axis clear the left deadzone
        write_reg(gpdk_pkg::CFG_BTN_MASK, 16'h0C00);
        write_reg(gpdk_pkg::CFG_LT_THR, 16'd128);
        write_reg(gpdk_pkg::CFG_RT_THR, 16'd128);
        write_reg(gpdk_pkg::CFG_LS_DZ, 16'd46340);
        write_reg(gpdk_pkg::CFG_RS_DZ, 16'd1);
        run_random(ITEMS_PER_PHASE);
        settle();

        if (fault_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
